// File: hdl/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg - shared types, constants and functions
// Format codes, digit pipeline payload and ASCII helpers for the formatter.
// ----------------------------------------------------------------------------
package b2a_pkg;

	typedef enum logic [1:0] {
		FMT_DEC = 2'd0,
		FMT_HEX = 2'd1,
		FMT_NL  = 2'd2
	} fmt_t;

	localparam int NUM_STAGES = 4;
	localparam int NUM_CHARS  = 5;
	localparam int LAST_IDX   = NUM_CHARS - 1;

	// place weights of the four leading decimal digits
	localparam int DEC_WEIGHT [NUM_STAGES] = '{10000, 1000, 100, 10};

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_A_OFF = 7'h37;
	localparam logic [6:0] CH_CR    = 7'h0D;
	localparam logic [6:0] CH_LF    = 7'h0A;

	typedef struct packed {
		fmt_t                              op;
		logic [15:0]                       rem;
		logic [NUM_STAGES-1:0][3:0]        dig;
	} pay_t;

	typedef struct packed {
		logic valid;
		pay_t pay;
	} pipe_out_t;

	// one decimal digit: compare against the nine multiples of the weight
	function automatic pay_t dec_step(input pay_t din, input int k);
		pay_t        dout;
		logic [16:0] thr;
		logic [16:0] sub;
		logic [3:0]  d;
		dout = din;
		sub  = '0;
		d    = '0;
		for (int j = 1; j <= 9; j++) begin
			thr = 17'(DEC_WEIGHT[k] * j);
			if ({1'b0, din.rem} >= thr) begin
				d   = 4'(j);
				sub = thr;
			end
		end
		if (din.op == FMT_DEC) begin
			dout.rem    = 16'({1'b0, din.rem} - sub);
			dout.dig[k] = d;
		end
		return dout;
	endfunction

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + 7'(nib);
		end else begin
			c = CH_A_OFF + 7'(nib);
		end
		return c;
	endfunction

endpackage

// File: hdl/b2a_digit_pipe.sv
// ----------------------------------------------------------------------------
// b2a_digit_pipe - decimal digit extraction pipeline
// Four register stages, each peeling one decimal digit off the value.
// ----------------------------------------------------------------------------
module b2a_digit_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  b2a_pkg::fmt_t     in_op,
	input  logic [15:0]       in_value,
	output b2a_pkg::pipe_out_t out,
	input  logic              out_ready
);
	import b2a_pkg::*;

	logic                 vld_s [1:NUM_STAGES];
	pay_t                 pay_s [1:NUM_STAGES];
	logic                 rdy   [1:NUM_STAGES+1];
	pay_t                 head;

	always_comb begin
		head.op  = in_op;
		head.rem = in_value;
		head.dig = '0;
	end

	assign rdy[NUM_STAGES+1] = out_ready;
	assign in_ready          = rdy[1];

	for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_stage
		logic vin;
		pay_t pin;

		if (k == 1) begin : g_first
			assign vin = in_valid;
			assign pin = head;
		end else begin : g_next
			assign vin = vld_s[k-1];
			assign pin = pay_s[k-1];
		end

		// a stage may advance when it is empty or the next one moves
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vin) begin
				pay_s[k] <= dec_step(pin, k - 1);
			end
		end
	end

	assign out.valid = vld_s[NUM_STAGES];
	assign out.pay   = pay_s[NUM_STAGES];

endmodule

// File: hdl/b2a_serializer.sv
// ----------------------------------------------------------------------------
// b2a_serializer - character output stage
// Builds the right-aligned character run of one item and sends it one
// character per cycle while m_tready is high, marking the last.
// ----------------------------------------------------------------------------
module b2a_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  b2a_pkg::pipe_out_t in,
	output logic               in_ready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [6:0] ascii_char, [7] zero
	output logic               m_tlast    // last_char
);
	import b2a_pkg::*;

	logic             busy_q;
	logic [2:0]       idx_q;
	logic [6:0]       chars_q [NUM_CHARS];
	logic [6:0]       chars_d [NUM_CHARS];
	logic [2:0]       start_d;
	logic             emit_d;
	logic [3:0]       digit [NUM_CHARS];
	logic             fire;
	logic             load;

	assign fire     = m_tvalid && m_tready;
	assign in_ready = !busy_q || (m_tready && idx_q == 3'(LAST_IDX));
	assign load     = in.valid && in_ready;

	always_comb begin
		for (int i = 0; i < NUM_STAGES; i++) begin
			digit[i] = in.pay.dig[i];
		end
		digit[LAST_IDX] = in.pay.rem[3:0];

		for (int i = 0; i < NUM_CHARS; i++) begin
			chars_d[i] = CH_ZERO + 7'(digit[i]);
		end
		start_d = 3'(LAST_IDX);
		emit_d  = 1'b1;

		case (in.pay.op)
			FMT_DEC: begin
				// suppress leading zeros, the units digit always stays
				for (int i = NUM_STAGES - 1; i >= 0; i--) begin
					if (digit[i] != 4'd0) begin
						start_d = 3'(i);
					end
				end
			end
			FMT_HEX: begin
				chars_d[LAST_IDX-1] = hex_char(in.pay.rem[7:4]);
				chars_d[LAST_IDX]   = hex_char(in.pay.rem[3:0]);
				start_d             = 3'(LAST_IDX - 1);
			end
			FMT_NL: begin
				chars_d[LAST_IDX-1] = CH_CR;
				chars_d[LAST_IDX]   = CH_LF;
				start_d             = 3'(LAST_IDX - 1);
			end
			default: begin
				// unused selector: drop the item
				emit_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= emit_d;
			idx_q  <= start_d;
		end else if (fire) begin
			if (idx_q == 3'(LAST_IDX)) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= chars_d;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {1'b0, chars_q[idx_q]};
	assign m_tlast  = (idx_q == 3'(LAST_IDX));

endmodule

// File: hdl/binary_to_ascii_number_formatter_core.sv
// ----------------------------------------------------------------------------
// Number to ASCII formatter, takes one request (value and format code) a
// cycle into a four-stage decimal digit pipeline while it is not stalled
// and sends the text out one character per cycle while m_tready is high.
// Throughput is set by the single-character output register: a request
// holds the output until all its characters are sent (decimal 1 to 5,
// hex 2, CR LF 2, unused code 0), so under full load the input accepts
// a new request only as the last character of the one before goes out.
// ----------------------------------------------------------------------------
// binary_to_ascii_number_formatter_core - top level
// Decimal, hex-byte and newline formatting with stream handshakes.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] value
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] ascii_char, [7] zero
	output logic        m_tlast    // last_char
);
	import b2a_pkg::*;

	pipe_out_t pipe_out;
	logic      ser_ready;

	b2a_digit_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (fmt_t'(s_tuser)),
		.in_value  (s_tdata),
		.out       (pipe_out),
		.out_ready (ser_ready)
	);

	b2a_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (pipe_out),
		.in_ready (ser_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hdl/b2a_checker.sv
// ----------------------------------------------------------------------------
// b2a_checker - port-level checks
// Checks input and output hold, character ordering and run marking.
// ----------------------------------------------------------------------------
module b2a_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);
	import b2a_pkg::*;

	// hold a waiting input item
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input item changed while waiting");

	// hold a stalled item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_lf_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:0] == CH_LF |-> m_tlast)
		else $error("LF not marked last");

	a_cr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:0] == CH_CR |-> !m_tlast)
		else $error("CR marked last");

	// LF follows an accepted CR in the very next cycle
	a_cr_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata[6:0] == CH_CR |=>
		m_tvalid && m_tdata[6:0] == CH_LF)
		else $error("CR not followed by LF");

endmodule

bind binary_to_ascii_number_formatter_core b2a_checker u_b2a_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
